// File: hw/rtl/quadrature_encoder_step_divider_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quadrature encoder step divider
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_ENCODER_STEP_DIVIDER_UNIT_ASSERT_SVH
`define QUADRATURE_ENCODER_STEP_DIVIDER_UNIT_ASSERT_SVH

`ifndef SYNTH

`define QSD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("qsd assertion failed");

`define QSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("qsd assertion failed");

`else

`define QSD_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define QSD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/qsd_pkg.sv
// ----------------------------------------------------------------------------
// Quadrature encoder step divider package
// Register indexes, field widths and reset values shared by the block.
// ----------------------------------------------------------------------------
package qsd_pkg;

    localparam int CountW    = 16;
    localparam int IntervalW = 15;
    localparam int PulseW    = 16;
    localparam int CfgDataW  = 16;
    localparam int CfgIdxW   = 2;

    typedef logic [CfgIdxW-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_STEP_INTERVAL = 2'd0;
    localparam t_cfg_idx CFG_THREAD_ENABLE = 2'd1;
    localparam t_cfg_idx CFG_PULSE_WIDTH   = 2'd2;

    localparam logic [IntervalW-1:0] STEP_INTERVAL_RST = 15'd100;
    localparam logic [PulseW-1:0]    PULSE_WIDTH_RST   = 16'd100;

endpackage

// File: hw/rtl/qsd_if.sv
// ----------------------------------------------------------------------------
// Quadrature encoder step divider channels
// Valid/ready channels for encoder samples and step results.
// ----------------------------------------------------------------------------
interface qsd_in_if;
    logic valid;
    logic ready;
    logic line_a;
    logic line_b;

    modport source (output valid, output line_a, output line_b, input ready);
    modport sink (input valid, input line_a, input line_b, output ready);
endinterface

interface qsd_out_if;
    logic                                valid;
    logic                                ready;
    logic                                step_out;
    logic                                fired;
    logic signed [qsd_pkg::CountW-1:0]   position;

    modport source (output valid, output step_out, output fired, output position,
                    input ready);
    modport sink (input valid, input step_out, input fired, input position,
                  output ready);
endinterface

// File: hw/rtl/quadrature_encoder_step_divider_unit.sv
// ----------------------------------------------------------------------------
// Quadrature encoder step divider
// Counts quadrature edges and issues motor step pulses every step_interval.
// ----------------------------------------------------------------------------
// Each sample of lines A and B is one transaction and yields one result
// transaction in the next cycle: step line level, fired flag and signed
// position count. Edge detection, interval compare, count update and pulse
// timer are combinational before the result register, so the block takes
// one sample per clock while results are taken; only the result register
// stalls the input. The user must write configuration registers through the
// plain write port only while idle; the block itself does not enforce this.
`include "quadrature_encoder_step_divider_unit_assert.svh"

module quadrature_encoder_step_divider_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  qsd_pkg::t_cfg_idx                  i_cfg_idx,
    input  logic [qsd_pkg::CfgDataW-1:0]       i_cfg_data,
    qsd_in_if.sink                             i_item,
    qsd_out_if.source                          o_result
);

    logic [qsd_pkg::IntervalW-1:0] r_step_interval;
    logic                          r_thread_en;
    logic [qsd_pkg::PulseW-1:0]    r_pulse_width;

    logic                          r_last_a;
    logic                          r_last_b;
    logic [qsd_pkg::CountW-1:0]    r_count;
    logic [qsd_pkg::PulseW-1:0]    r_pulse_left;

    logic                          r_out_valid;
    logic                          r_out_step;
    logic                          r_out_fired;
    logic [qsd_pkg::CountW-1:0]    r_out_pos;

    logic                          accept;
    logic                          rise_a;
    logic                          rise_b;
    logic                          fire_a;
    logic                          fire_b;
    logic                          fire;
    logic [qsd_pkg::CountW-1:0]    count_a;
    logic [qsd_pkg::CountW-1:0]    base_b;
    logic [qsd_pkg::CountW-1:0]    n_count;
    logic [qsd_pkg::PulseW-1:0]    pulse_load;
    logic [qsd_pkg::PulseW-1:0]    pulse_cur;
    logic                          n_step;
    logic [qsd_pkg::PulseW-1:0]    n_pulse_left;

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign accept       = i_item.valid && i_item.ready;

    assign rise_a = i_item.line_a && !r_last_a;
    assign rise_b = i_item.line_b && !r_last_b;

    always_comb begin
        fire_a  = rise_a && r_thread_en && !r_count[qsd_pkg::CountW-1]
                  && (r_count[qsd_pkg::IntervalW-1:0] >= r_step_interval);
        count_a = fire_a ? '0 : r_count;
        if (rise_a) begin
            count_a = i_item.line_b ? count_a - qsd_pkg::CountW'(1)
                                    : count_a + qsd_pkg::CountW'(1);
        end

        fire_b  = rise_b && r_thread_en && !count_a[qsd_pkg::CountW-1]
                  && (count_a[qsd_pkg::IntervalW-1:0] >= r_step_interval);
        base_b  = fire_b ? '0 : count_a;
        n_count = base_b;
        if (rise_b) begin
            n_count = i_item.line_a ? base_b + qsd_pkg::CountW'(1)
                                    : base_b - qsd_pkg::CountW'(1);
        end

        fire         = fire_a || fire_b;
        pulse_load   = (r_pulse_width == '0) ? qsd_pkg::PulseW'(1) : r_pulse_width;
        pulse_cur    = fire ? pulse_load : r_pulse_left;
        n_step       = (pulse_cur != '0);
        n_pulse_left = n_step ? pulse_cur - qsd_pkg::PulseW'(1) : pulse_cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_interval <= qsd_pkg::STEP_INTERVAL_RST;
            r_thread_en     <= 1'b0;
            r_pulse_width   <= qsd_pkg::PULSE_WIDTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                qsd_pkg::CFG_STEP_INTERVAL: begin
                    r_step_interval <= i_cfg_data[qsd_pkg::IntervalW-1:0];
                end
                qsd_pkg::CFG_THREAD_ENABLE: begin
                    r_thread_en <= i_cfg_data[0];
                end
                qsd_pkg::CFG_PULSE_WIDTH: begin
                    r_pulse_width <= i_cfg_data[qsd_pkg::PulseW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_a     <= 1'b1;
            r_last_b     <= 1'b1;
            r_count      <= '0;
            r_pulse_left <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_last_a     <= i_item.line_a;
                r_last_b     <= i_item.line_b;
                r_count      <= n_count;
                r_pulse_left <= n_pulse_left;
                r_out_valid  <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_step  <= n_step;
            r_out_fired <= fire;
            r_out_pos   <= n_count;
        end
    end

    assign o_result.valid    = r_out_valid;
    assign o_result.step_out = r_out_step;
    assign o_result.fired    = r_out_fired;
    assign o_result.position = $signed(r_out_pos);

    `QSD_ASSERT_SAME(a_fired_drives_step, i_clk, i_rst_n, o_result.valid && o_result.fired, o_result.step_out)
    `QSD_ASSERT_SAME(a_no_fire_when_disabled, i_clk, i_rst_n, accept && !r_thread_en, !fire)
    `QSD_ASSERT_NEXT(a_count_holds_without_edge, i_clk, i_rst_n, accept && !rise_a && !rise_b, r_count == $past(r_count))
    `QSD_ASSERT_NEXT(a_idle_pulse_stays_idle, i_clk, i_rst_n, accept && !fire && (r_pulse_left == '0), r_pulse_left == '0)

endmodule

// File: bench/quadrature_encoder_step_divider_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature encoder step divider testbench
// Drives encoder samples over the valid/ready input channel with bursty
// traffic while the result channel stalls on its own pattern. A scoreboard
// class predicts step level, fired flag and position for every accepted
// sample and checks each result transaction in order. Phases cover several
// interval, enable and pulse width settings, a long back-pressure stretch and
// a run at the top interval.
// ----------------------------------------------------------------------------
module quadrature_encoder_step_divider_unit_tb;

    localparam qsd_pkg::t_cfg_idx CFG_UNUSED  = 2'd3;
    localparam int                HOLD_CYCLES = 400;
    localparam int                PHASE_ITEMS = 300;

    typedef struct packed {
        logic                              step_out;
        logic                              fired;
        logic signed [qsd_pkg::CountW-1:0] position;
    } t_step_result;

    class t_step_scoreboard;
        logic [qsd_pkg::IntervalW-1:0] interval;
        logic                          enable;
        logic [qsd_pkg::PulseW-1:0]    width;
        logic                          prev_a;
        logic                          prev_b;
        logic [qsd_pkg::CountW-1:0]    count;
        logic [qsd_pkg::PulseW-1:0]    pulse_left;
        t_step_result                  pending[$];
        int                            errors;
        int                            checked;
        int                            fired_total;
        int                            step_ticks;

        function new();
            interval    = qsd_pkg::STEP_INTERVAL_RST;
            enable      = 1'b0;
            width       = qsd_pkg::PULSE_WIDTH_RST;
            prev_a      = 1'b1;
            prev_b      = 1'b1;
            count       = '0;
            pulse_left  = '0;
            errors      = 0;
            checked     = 0;
            fired_total = 0;
            step_ticks  = 0;
        endfunction

        function void write_reg(qsd_pkg::t_cfg_idx idx, logic [qsd_pkg::CfgDataW-1:0] data);
            case (idx)
                qsd_pkg::CFG_STEP_INTERVAL: interval = data[qsd_pkg::IntervalW-1:0];
                qsd_pkg::CFG_THREAD_ENABLE: enable = data[0];
                qsd_pkg::CFG_PULSE_WIDTH:   width = data[qsd_pkg::PulseW-1:0];
                default: ;
            endcase
        endfunction

        function bit count_edge(bit up);
            bit fire;
            fire = 1'b0;
            if (enable && ($signed(count) >= $signed({1'b0, interval}))) begin
                count      = '0;
                pulse_left = (width == '0) ? 16'd1 : width;
                fire       = 1'b1;
            end
            count = up ? count + 16'd1 : count - 16'd1;
            return fire;
        endfunction

        function void note_sample(logic a, logic b);
            t_step_result res;
            bit           fire;
            fire = 1'b0;
            if (a && !prev_a) begin
                if (count_edge(!b)) fire = 1'b1;
            end
            if (b && !prev_b) begin
                if (count_edge(a)) fire = 1'b1;
            end
            prev_a       = a;
            prev_b       = b;
            res.step_out = (pulse_left != '0);
            if (pulse_left != '0) pulse_left = pulse_left - 16'd1;
            res.fired    = fire;
            res.position = count;
            pending.push_back(res);
        endfunction

        function void check_result(logic step, logic fire,
                                   logic signed [qsd_pkg::CountW-1:0] pos);
            t_step_result exp;
            if (pending.size() == 0) begin
                $error("result transaction with no sample pending: %s%0b %s%0b %s%0d",
                       "step_out=", step, "fired=", fire, "position=", pos);
                errors++;
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (exp.fired) fired_total++;
            if (exp.step_out) step_ticks++;
            if (step !== exp.step_out) begin
                $error("step_out mismatch: expected %0b, actual %0b", exp.step_out, step);
                errors++;
            end
            if (fire !== exp.fired) begin
                $error("fired mismatch: expected %0b, actual %0b", exp.fired, fire);
                errors++;
            end
            if (pos !== exp.position) begin
                $error("position mismatch: expected %0d, actual %0d", exp.position, pos);
                errors++;
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    qsd_pkg::t_cfg_idx             i_cfg_idx;
    logic [qsd_pkg::CfgDataW-1:0]  i_cfg_data;

    qsd_in_if  in_ch ();
    qsd_out_if out_ch ();

    t_step_scoreboard sb;
    logic cur_a = 1'b1;
    logic cur_b = 1'b1;
    int   dir_left = 0;
    bit   run_fwd = 1'b1;
    bit   hold_req = 1'b0;
    int   hold_left = 0;
    int   seg_left = 0;
    int   seg_mode = 0;

    quadrature_encoder_step_divider_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (in_ch),
        .o_result   (out_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.step_out, out_ch.fired, out_ch.position);
            if (in_ch.valid && in_ch.ready)
                sb.note_sample(in_ch.line_a, in_ch.line_b);
        end
    end

    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                if (seg_left == 0) begin
                    seg_mode = $urandom_range(0, 2);
                    seg_left = $urandom_range(5, 120);
                end
                seg_left--;
                case (seg_mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(0, 1));
                    default: out_ch.ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    initial begin
        #16ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int gray_index(logic [1:0] ab);
        case (ab)
            2'b00: return 0;
            2'b10: return 1;
            2'b11: return 2;
            default: return 3;
        endcase
    endfunction

    function automatic logic [1:0] gray_level(int idx);
        case (idx % 4)
            0: return 2'b00;
            1: return 2'b10;
            2: return 2'b11;
            default: return 2'b01;
        endcase
    endfunction

    function automatic logic [1:0] pick_sample();
        int         r;
        int         idx;
        logic [1:0] v;
        if (dir_left == 0) begin
            run_fwd  = 1'($urandom_range(0, 1));
            dir_left = $urandom_range(2, 50);
        end
        dir_left--;
        r   = $urandom_range(0, 99);
        idx = gray_index({cur_a, cur_b});
        if (r < 75) return gray_level(run_fwd ? idx + 1 : idx + 3);
        if (r < 85) return {cur_a, cur_b};
        if (r < 92) return {~cur_a, ~cur_b};
        v = 2'($urandom_range(0, 3));
        return v;
    endfunction

    task automatic send_sample(input logic a, input logic b);
        in_ch.valid  <= 1'b1;
        in_ch.line_a <= a;
        in_ch.line_b <= b;
        cur_a = a;
        cur_b = b;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
    endtask

    task automatic send_packed(input logic [31:0] seq, input int n);
        logic [1:0] ab;
        for (int i = 0; i < n; i++) begin
            ab = seq[2*(n-1-i) +: 2];
            send_sample(ab[1], ab[0]);
        end
        in_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input qsd_pkg::t_cfg_idx idx,
                             input logic [qsd_pkg::CfgDataW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [qsd_pkg::CfgDataW-1:0] interval, input bit en,
                              input logic [qsd_pkg::CfgDataW-1:0] width);
        logic [qsd_pkg::CfgDataW-1:0] en_word;
        en_word = (16'($urandom_range(0, 65535)) & 16'hFFFE) | {15'd0, en};
        write_reg(qsd_pkg::CFG_STEP_INTERVAL, interval);
        write_reg(qsd_pkg::CFG_THREAD_ENABLE, en_word);
        write_reg(qsd_pkg::CFG_PULSE_WIDTH, width);
    endtask

    task automatic random_run(input int n_items);
        int         sent;
        int         burst;
        int         gap;
        logic [1:0] ab;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && sent < n_items; i++) begin
                ab = pick_sample();
                send_sample(ab[1], ab[0]);
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_ch.valid <= 1'b0;
    endtask

    task automatic sweep_edges(input bit up, input int n_edges);
        int         done_edges;
        int         idx;
        logic [1:0] nxt;
        done_edges = 0;
        while (done_edges < n_edges) begin
            idx = gray_index({cur_a, cur_b});
            nxt = gray_level(up ? idx + 1 : idx + 3);
            if ((nxt[1] && !cur_a) || (nxt[0] && !cur_b)) done_edges++;
            send_sample(nxt[1], nxt[0]);
        end
        in_ch.valid <= 1'b0;
    endtask

    initial begin
        sb = new();
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= qsd_pkg::CFG_STEP_INTERVAL;
        i_cfg_data   <= '0;
        in_ch.valid  <= 1'b0;
        in_ch.line_a <= 1'b1;
        in_ch.line_b <= 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: count only
        send_packed(32'b00_10_11_01_00, 5);
        wait_drained();

        // interval zero via masked bit 15, zero pulse width
        set_config(16'h8000, 1'b1, 16'd0);
        send_packed(32'b01_11_00_11_00_10_11_00_11, 9);
        wait_drained();

        // restart pulses while still high
        set_config(16'd1, 1'b1, 16'd5);
        send_packed(32'b00_10_11_01_00_10_11_01_00_10, 10);
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_config(16'd0, 1'b1, 16'd1);
                1: set_config(16'($urandom_range(1, 6)), 1'b1, 16'($urandom_range(2, 20)));
                2: set_config(16'($urandom_range(0, 65535)), 1'b0,
                              16'($urandom_range(1, 65535)));
                3: set_config(16'($urandom_range(0, 15)), 1'b1, 16'd0);
                4: set_config(16'd2, 1'b1, 16'($urandom_range(30, 300)));
                default: begin
                    write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
                    set_config(16'($urandom_range(0, 30)), 1'b1,
                               16'($urandom_range(1, 65535)));
                end
            endcase
            if (p == 1) begin
                random_run(PHASE_ITEMS / 2);
                hold_req = 1'b1;
                random_run(PHASE_ITEMS / 2);
            end else if (p == 3) begin
                random_run(PHASE_ITEMS / 2);
                wait_drained();
                random_run(PHASE_ITEMS / 2);
            end else begin
                random_run(PHASE_ITEMS);
            end
            wait_drained();
        end

        set_config(16'h7FFF, 1'b1, 16'hFFFF);
        sweep_edges(1'b1, 1);
        random_run(40);
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            $error("%0d expected results never arrived", sb.pending.size());
            sb.errors += sb.pending.size();
        end
        $display("Summary: %0d result transactions checked, %0d step firings, %0d %s",
                 sb.checked, sb.fired_total, sb.step_ticks, "step-high ticks");
        $display("Summary: intervals 0 to 32767, pulse widths 0 to 65535, both directions");
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/qsd_pkg.sv
hw/rtl/qsd_if.sv
hw/rtl/quadrature_encoder_step_divider_unit.sv
bench/quadrature_encoder_step_divider_unit_tb.sv
